// ----- sv/ptb_pkg.sv -----
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types, opcodes and constants of the periodic timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 48;

  localparam int OPCODE_W = 2;
  localparam int SLOT_FW  = 4;
  localparam int PERIOD_W = 32;
  localparam int NOW_W    = 48;
  localparam int WAIT_W   = 31;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd100;
  localparam logic [WAIT_W-1:0]   WAIT_MAX     = 31'h7FFF_FFFF;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET   = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_RUN   = 2'd3
  } op_t;

  typedef struct packed {
    logic op_wr;
    logic scan_start;
    logic advance;
    logic load_fire;
    logic load_sum;
  } ptb_cmd_t;

  typedef struct packed {
    logic due;
    logic idx_last;
    logic out_free;
  } ptb_stat_t;

endpackage

`default_nettype wire

// ----- sv/ptb_if.sv -----
// ----------------------------------------------------------------------------
// ptb_in_if / ptb_out_if
// Valid/ready channels carrying command words in and result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptb_in_if;
  import ptb_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SLOT_FW-1:0]  slot;
  logic [PERIOD_W-1:0] period;
  logic [NOW_W-1:0]    now;

  modport source (output valid, output opcode, output slot, output period,
                  output now, input ready);
  modport sink   (input valid, input opcode, input slot, input period,
                  input now, output ready);
endinterface

interface ptb_out_if;
  import ptb_pkg::*;

  logic               valid;
  logic               ready;
  logic               fired;
  logic [SLOT_FW-1:0] fired_slot;
  logic [WAIT_W-1:0]  wait_time;
  logic               last;

  modport source (output valid, output fired, output fired_slot,
                  output wait_time, output last, input ready);
  modport sink   (input valid, input fired, input fired_slot,
                  input wait_time, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/periodic_timer_bank_unit.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_bank_unit
// Bank of periodic timers with set, start, stop and run-scan commands.
// ----------------------------------------------------------------------------
// Set-interval, start and stop words produce no result. A run word scans
// the slots in index order, one slot per cycle from the single read port
// of the slot storage, except that a due slot waits while the result
// register is not free. Each due slot sends a fired word; the scan ends
// with a summary word (last high) holding the wait until the earliest
// pending deadline. No clearing pass is needed after reset; a new word is
// taken once the previous scan has issued its summary into the output
// register.
`default_nettype none

module periodic_timer_bank_unit #(
  parameter int NUM_SLOTS = ptb_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = ptb_pkg::TIME_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ptb_in_if.sink   in_chan,
  ptb_out_if.source out_chan
);
  import ptb_pkg::*;

  ptb_cmd_t  cmd;
  ptb_stat_t stat;

  ptb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_opcode (in_chan.opcode),
    .in_ready  (in_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptb_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_chan.opcode),
    .in_slot        (in_chan.slot),
    .in_period      (in_chan.period),
    .in_now         (in_chan.now),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .out_fired      (out_chan.fired),
    .out_fired_slot (out_chan.fired_slot),
    .out_wait_time  (out_chan.wait_time),
    .out_last       (out_chan.last)
  );

endmodule

`default_nettype wire

// ----- sv/ptb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptb_ctrl
// Sequencer: takes command words, steps the slot scan, paces result words.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [ptb_pkg::OPCODE_W-1:0] in_opcode,
  output logic                             in_ready,
  input  ptb_pkg::ptb_stat_t               stat,
  output ptb_pkg::ptb_cmd_t                cmd
);
  import ptb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_SUM  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_RUN) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_EVAL;
          end else begin
            cmd.op_wr = 1'b1;
          end
        end
      end
      ST_EVAL: begin
        if (stat.due) begin
          cmd.load_fire = stat.out_free;
          cmd.advance   = stat.out_free;
        end else begin
          cmd.advance = 1'b1;
        end
        if (cmd.advance && stat.idx_last) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (stat.out_free) begin
          cmd.load_sum = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ptb_dp.sv -----
// ----------------------------------------------------------------------------
// ptb_dp
// Slot storage, deadline update, earliest-deadline tracking, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_dp #(
  parameter int NUM_SLOTS = ptb_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = ptb_pkg::TIME_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [ptb_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic [ptb_pkg::SLOT_FW-1:0]  in_slot,
  input  wire logic [ptb_pkg::PERIOD_W-1:0] in_period,
  input  wire logic [ptb_pkg::NOW_W-1:0]    in_now,
  input  ptb_pkg::ptb_cmd_t                cmd,
  output ptb_pkg::ptb_stat_t               stat,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic                             out_fired,
  output logic [ptb_pkg::SLOT_FW-1:0]       out_fired_slot,
  output logic [ptb_pkg::WAIT_W-1:0]        out_wait_time,
  output logic                             out_last
);
  import ptb_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SW     = ((TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MASK = {TIME_BITS{1'b1}};
  localparam logic [SW-1:0]        MASK_W    = SW'(TIME_MASK);

  logic [PERIOD_W-1:0]  per_mem_r [NUM_SLOTS];
  logic [TIME_BITS-1:0] dl_mem_r  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] pv_r, dv_r, run_r;

  logic [PERIOD_W-1:0]  rd_per_r;
  logic [TIME_BITS-1:0] rd_dl_r;
  logic                 rd_pv_r, rd_dv_r, rd_run_r;

  logic [SLOT_W-1:0]    idx_r;
  logic [TIME_BITS-1:0] now_r, earliest_r;

  logic                 out_valid_r, out_fired_r, out_last_r;
  logic [SLOT_FW-1:0]   out_slot_r;
  logic [WAIT_W-1:0]    out_wait_r;

  logic [63:0]          now64;
  logic [TIME_BITS-1:0] now_t;
  logic [SLOT_W-1:0]    wr_addr, rd_addr;
  logic                 slot_ok, rd_en;
  logic [PERIOD_W-1:0]  per_eff;
  logic [TIME_BITS-1:0] dl_eff, dl_new, diff;
  logic [SW-1:0]        sum_w;
  logic                 active, due;
  logic [63:0]          diff64;
  logic [WAIT_W-1:0]    wait_v;
  logic                 out_free;

  assign now64   = 64'(in_now);
  assign now_t   = now64[TIME_BITS-1:0];
  assign slot_ok = 32'(in_slot) < NUM_SLOTS;
  assign wr_addr = SLOT_W'(in_slot);

  assign stat.idx_last = (idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign rd_en   = cmd.scan_start || (cmd.advance && !stat.idx_last);
  assign rd_addr = cmd.scan_start ? '0 : idx_r + 1'b1;

  assign per_eff = rd_pv_r ? rd_per_r : PERIOD_RESET;
  assign dl_eff  = rd_dv_r ? rd_dl_r : TIME_MASK;
  assign active  = rd_run_r && !per_eff[PERIOD_W-1];
  assign due     = active && (now_r >= dl_eff);
  assign sum_w   = SW'(dl_eff) + SW'(per_eff[PERIOD_W-2:0]);
  assign dl_new  = (sum_w > MASK_W) ? TIME_MASK : sum_w[TIME_BITS-1:0];

  assign diff   = earliest_r - now_r;
  assign diff64 = 64'(diff);
  always_comb begin
    if (earliest_r == TIME_MASK) begin
      wait_v = '0;
    end else if (diff64 > 64'(WAIT_MAX)) begin
      wait_v = WAIT_MAX;
    end else begin
      wait_v = diff64[WAIT_W-1:0];
    end
  end

  assign out_free      = !out_valid_r || out_ready;
  assign stat.due      = due;
  assign stat.out_free = out_free;

  // slot storage
  always_ff @(posedge clk) begin
    if (cmd.op_wr && slot_ok && in_opcode == OP_SET) begin
      per_mem_r[wr_addr] <= in_period;
    end
    if (cmd.op_wr && slot_ok && in_opcode == OP_START) begin
      dl_mem_r[wr_addr] <= now_t;
    end else if (cmd.load_fire) begin
      dl_mem_r[idx_r] <= dl_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_per_r <= per_mem_r[rd_addr];
      rd_dl_r  <= dl_mem_r[rd_addr];
      rd_pv_r  <= pv_r[rd_addr];
      rd_dv_r  <= dv_r[rd_addr];
      rd_run_r <= run_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= '0;
      dv_r  <= '0;
      run_r <= '0;
    end else begin
      if (cmd.op_wr && slot_ok) begin
        unique case (in_opcode)
          OP_SET:   pv_r[wr_addr] <= 1'b1;
          OP_START: begin
            dv_r[wr_addr]  <= 1'b1;
            run_r[wr_addr] <= 1'b1;
          end
          OP_STOP:  run_r[wr_addr] <= 1'b0;
          default:  ;
        endcase
      end
      if (cmd.load_fire) begin
        dv_r[idx_r] <= 1'b1;
      end
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.advance) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      now_r      <= now_t;
      earliest_r <= TIME_MASK;
    end else if (cmd.advance && active && !due && dl_eff < earliest_r) begin
      earliest_r <= dl_eff;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_fire || cmd.load_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_fire) begin
      out_fired_r <= 1'b1;
      out_slot_r  <= SLOT_FW'(idx_r);
      out_wait_r  <= '0;
      out_last_r  <= 1'b0;
    end else if (cmd.load_sum) begin
      out_fired_r <= 1'b0;
      out_slot_r  <= '0;
      out_wait_r  <= wait_v;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fired      = out_fired_r;
  assign out_fired_slot = out_slot_r;
  assign out_wait_time  = out_wait_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire
